// ----- hdl/tmo_pkg.sv -----
// shared types and constants for the texture mip offset calculator
package tmo_pkg;

	// mip levels addressable by a 5-bit level field
	localparam int LVL_W  = 5;
	localparam int LEVELS = 1 << LVL_W;

	// levels summed into the per-slice size and the prefix offsets
	localparam int MAX_MIPS = 16;

	// ceil divider: dividend is a 16-bit dim plus up to 30
	localparam int DVD_W     = 17;
	localparam int DIV_STEPS = DVD_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// register reset values
	localparam logic [15:0] RST_BASE_WIDTH  = 16'd1;
	localparam logic [15:0] RST_BASE_HEIGHT = 16'd1;
	localparam logic [4:0]  RST_MIP_COUNT   = 5'd1;
	localparam logic [4:0]  RST_BLOCK_DIM   = 5'd1;
	localparam logic [4:0]  RST_BLOCK_BYTES = 5'd4;

	typedef enum logic [2:0] {
		REG_BASE_WIDTH  = 3'd0,
		REG_BASE_HEIGHT = 3'd1,
		REG_MIP_COUNT   = 3'd2,
		REG_BLOCK_DIM   = 3'd3,
		REG_BLOCK_BYTES = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] base_width;
		logic [15:0] base_height;
		logic [4:0]  mip_count;
		logic [4:0]  block_dim;
		logic [4:0]  block_bytes;
	} cfg_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_LOAD,
		B_DIV,
		B_MUL,
		B_SCALE
	} build_state_t;

	// read port of the level tables
	typedef struct packed {
		logic [31:0] size;
		logic [31:0] prefix;
	} tab_rd_t;

endpackage

// ----- hdl/tmo_build.sv -----
// configuration registers and the per-level size and prefix table builder
module tmo_build import tmo_pkg::*; #(
	parameter int MIP_SUM_LEVELS = MAX_MIPS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_wdata,
	output logic             busy,
	output logic [31:0]      slice_bytes,
	input  logic [LVL_W-1:0] rd_level,
	output tab_rd_t          rd
);

	cfg_t               cfg_q;
	build_state_t       state_q, state_d;
	logic [LVL_W-1:0]   lvl_q;
	logic [STEP_W-1:0]  step_q;
	logic [DVD_W-1:0]   dvd_w_q, dvd_h_q;
	logic [DVD_W-1:0]   quo_w_q, quo_h_q;
	logic [4:0]         rem_w_q, rem_h_q;
	logic [31:0]        texels_q;
	logic [31:0]        acc_q;
	logic [31:0]        slice_q;
	logic [31:0]        size_tab_q [LEVELS];
	logic [31:0]        pre_tab_q  [LEVELS];

	logic               cfg_wr;
	logic               last_step, last_lvl, in_sum;
	logic [4:0]         div_eff;
	logic [15:0]        sh_w, sh_h, dim_w, dim_h;
	logic [5:0]         trial_w, trial_h;
	logic               ge_w, ge_h;
	logic [36:0]        scaled;
	logic [31:0]        size_now;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign busy      = (state_q != B_IDLE);
	assign slice_bytes = slice_q;
	assign rd.size   = size_tab_q[rd_level];
	assign rd.prefix = pre_tab_q[rd_level];

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_width  <= RST_BASE_WIDTH;
			cfg_q.base_height <= RST_BASE_HEIGHT;
			cfg_q.mip_count   <= RST_MIP_COUNT;
			cfg_q.block_dim   <= RST_BLOCK_DIM;
			cfg_q.block_bytes <= RST_BLOCK_BYTES;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_BASE_WIDTH:  cfg_q.base_width  <= cfg_wdata;
				REG_BASE_HEIGHT: cfg_q.base_height <= cfg_wdata;
				REG_MIP_COUNT:   cfg_q.mip_count   <= cfg_wdata[4:0];
				REG_BLOCK_DIM:   cfg_q.block_dim   <= cfg_wdata[4:0];
				REG_BLOCK_BYTES: cfg_q.block_bytes <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	// level dims, floor of one, block edge of zero or one is plain
	always_comb begin
		div_eff = (cfg_q.block_dim > 5'd1) ? cfg_q.block_dim : 5'd1;
		sh_w    = cfg_q.base_width >> lvl_q;
		sh_h    = cfg_q.base_height >> lvl_q;
		dim_w   = (sh_w == 16'd0) ? 16'd1 : sh_w;
		dim_h   = (sh_h == 16'd0) ? 16'd1 : sh_h;
		trial_w = {rem_w_q, dvd_w_q[DVD_W-1]};
		trial_h = {rem_h_q, dvd_h_q[DVD_W-1]};
		ge_w    = (trial_w >= {1'b0, div_eff});
		ge_h    = (trial_h >= {1'b0, div_eff});
		scaled  = 37'(texels_q) * 37'(cfg_q.block_bytes);
		size_now = scaled[31:0];
		last_step = (step_q == STEP_W'(DIV_STEPS - 1));
		last_lvl  = (lvl_q == LVL_W'(LEVELS - 1));
		in_sum    = ({1'b0, lvl_q} < (LVL_W + 1)'(MIP_SUM_LEVELS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:  state_d = B_IDLE;
			B_LOAD:  state_d = B_DIV;
			B_DIV:   state_d = last_step ? B_MUL : B_DIV;
			B_MUL:   state_d = B_SCALE;
			B_SCALE: state_d = last_lvl ? B_IDLE : B_LOAD;
			default: state_d = B_IDLE;
		endcase
		// any register write starts the rebuild over
		if (cfg_wr) begin
			state_d = B_LOAD;
		end
	end

	// level counter, running prefix and per-slice total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q   <= '0;
			acc_q   <= '0;
			slice_q <= '0;
		end else if (cfg_wr) begin
			lvl_q <= '0;
			acc_q <= '0;
		end else if (state_q == B_SCALE) begin
			if (lvl_q == cfg_q.mip_count) begin
				slice_q <= acc_q;
			end
			if (in_sum) begin
				acc_q <= acc_q + size_now;
			end
			lvl_q <= lvl_q + LVL_W'(1);
		end
	end

	// ceil divider, width and height side by side, then texel and byte scale
	always_ff @(posedge clk) begin
		case (state_q)
			B_LOAD: begin
				dvd_w_q <= DVD_W'(dim_w) + DVD_W'(div_eff) - DVD_W'(1);
				dvd_h_q <= DVD_W'(dim_h) + DVD_W'(div_eff) - DVD_W'(1);
				rem_w_q <= '0;
				rem_h_q <= '0;
				quo_w_q <= '0;
				quo_h_q <= '0;
				step_q  <= '0;
			end
			B_DIV: begin
				rem_w_q <= ge_w ? 5'(trial_w - {1'b0, div_eff}) : trial_w[4:0];
				rem_h_q <= ge_h ? 5'(trial_h - {1'b0, div_eff}) : trial_h[4:0];
				quo_w_q <= {quo_w_q[DVD_W-2:0], ge_w};
				quo_h_q <= {quo_h_q[DVD_W-2:0], ge_h};
				dvd_w_q <= {dvd_w_q[DVD_W-2:0], 1'b0};
				dvd_h_q <= {dvd_h_q[DVD_W-2:0], 1'b0};
				step_q  <= step_q + STEP_W'(1);
			end
			B_MUL: begin
				texels_q <= quo_w_q[15:0] * quo_h_q[15:0];
			end
			B_SCALE: begin
				if (!cfg_wr) begin
					size_tab_q[lvl_q] <= size_now;
					pre_tab_q[lvl_q]  <= acc_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- hdl/tmo_pipe.sv -----
// four-stage request pipeline: table read, slice multiply, offset add
module tmo_pipe import tmo_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [10:0]      slice_index,
	input  logic [4:0]       mip_level,
	output logic [LVL_W-1:0] rd_level,
	input  tab_rd_t          rd,
	input  logic [31:0]      slice_total,
	output logic             done,
	output logic [31:0]      subres_offset,
	output logic [31:0]      level_bytes,
	output logic [31:0]      slice_bytes
);

	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [10:0] slice_s1, slice_s2;
	logic [4:0]  level_s1;
	logic [31:0] size_s2, pre_s2, size_s3, pre_s3, prod_s3, total_s3;
	logic [31:0] offset_s4, size_s4, total_s4;
	logic [42:0] prod_full;

	assign rd_level  = level_s1;
	assign prod_full = 43'(slice_s2) * 43'(slice_total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		slice_s1  <= slice_index;
		level_s1  <= mip_level;
		slice_s2  <= slice_s1;
		size_s2   <= rd.size;
		pre_s2    <= rd.prefix;
		prod_s3   <= prod_full[31:0];
		size_s3   <= size_s2;
		pre_s3    <= pre_s2;
		total_s3  <= slice_total;
		offset_s4 <= prod_s3 + pre_s3;
		size_s4   <= size_s3;
		total_s4  <= total_s3;
	end

	assign done          = vld_s4;
	assign subres_offset = offset_s4;
	assign level_bytes   = size_s4;
	assign slice_bytes   = total_s4;

endmodule

// ----- hdl/texture_mip_offset_calc.sv -----
// top level of the texture mip offset calculator
//
//  channel   handshake              payload
//  --------  ---------------------  ------------------------------------------
//  request   start / busy           slice_index[10:0], mip_level[4:0]
//  result    done (1-cycle strobe)  subres_offset[31:0], level_bytes[31:0],
//                                   slice_bytes[31:0]
//  config    cfg_valid / cfg_ready  cfg_index[2:0], cfg_wdata[15:0]
//
// a request word is taken at any edge with start high and busy low, one per
// cycle; its result shows on done after pipeline stages s1 to s4, in request order
// after reset and after every register write the level tables are rebuilt,
// all 32 levels in turn, each by dim load, 17-step ceil divide, texel
// multiply and byte scale, with busy high until the last level is done
// cfg_ready is always high; a write restarts the rebuild from level zero
// the result side has no back-pressure, so the pipeline never holds
module texture_mip_offset_calc import tmo_pkg::*; #(
	// levels summed into the per-slice size and the prefix offsets
	parameter int MIP_SUM_LEVELS = MAX_MIPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [10:0] slice_index,
	input  logic [4:0]  mip_level,
	output logic        done,
	output logic [31:0] subres_offset,
	output logic [31:0] level_bytes,
	output logic [31:0] slice_bytes,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic             accept;
	logic [LVL_W-1:0] rd_level;
	tab_rd_t          rd;
	logic [31:0]      slice_total;

	// tables are stable whenever busy is low, so the pipe reads them freely
	assign accept = start & ~busy;

	// register file plus iterative builder of per-level size and prefix
	tmo_build #(
		.MIP_SUM_LEVELS (MIP_SUM_LEVELS)
	) u_build (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.busy        (busy),
		.slice_bytes (slice_total),
		.rd_level    (rd_level),
		.rd          (rd)
	);

	// s1 capture, s2 table read, s3 slice times slice size, s4 offset add
	tmo_pipe u_pipe (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.slice_index   (slice_index),
		.mip_level     (mip_level),
		.rd_level      (rd_level),
		.rd            (rd),
		.slice_total   (slice_total),
		.done          (done),
		.subres_offset (subres_offset),
		.level_bytes   (level_bytes),
		.slice_bytes   (slice_bytes)
	);

endmodule
